>>> src/mlfd_pkg.sv
// Package for the magic/length frame deframer.
// Holds protocol constants, register indexes, error codes and the result record.
// Used by the deframer core and its port checker.
`timescale 1ns / 1ps
package mlfd_pkg;

   // Framing constants.
   localparam int unsigned HEADER_BYTES = 16;
   localparam logic [7:0] MAGIC_FIRST   = 8'h48;
   localparam logic [7:0] MAGIC_SECOND  = 8'h53;
   localparam logic [7:0] BRACE_OPEN    = 8'h7B;
   localparam logic [7:0] BRACE_CLOSE   = 8'h7D;

   // Default sizes.
   localparam int unsigned DEF_LINK_COUNT   = 4;
   localparam int unsigned DEF_BUFFER_BYTES = 1024;

   // Register file.
   localparam logic CSR_EXPECTED_VERSION = 1'b0;
   localparam logic CSR_MAX_BODY_BYTES   = 1'b1;
   localparam logic [7:0] RESET_VERSION  = 8'd1;
   localparam logic [9:0] RESET_MAX_BODY = 10'd1008;

   // Request kinds.
   localparam logic KIND_BYTE       = 1'b0;
   localparam logic KIND_LINK_RESET = 1'b1;

   // Error codes.
   typedef enum logic [1:0] {
      ERR_BAD_MAGIC   = 2'd0,
      ERR_BAD_VERSION = 2'd1,
      ERR_TOO_LARGE   = 2'd2,
      ERR_BAD_BRACES  = 2'd3
   } err_code_type;

   // One result record.
   typedef struct packed {
      logic         is_error;
      err_code_type error_code;
      logic [1:0]   out_link;
      logic [15:0]  message_type;
      logic [31:0]  sequence_res;
      logic [9:0]   body_length;
   } result_type;

endpackage

>>> src/magic_length_frame_deframer_core.sv
// Top level of the magic/length frame deframer: link buffers, header parser, result register.
// Depends on mlfd_pkg.
`timescale 1ns / 1ps
// Each request carries one byte for a link or a reset of that link. Bytes land in a
// per-link ring inside one synchronous buffer memory with a single read port. A byte
// request that leaves its link holding fewer than 16 bytes is only written. Once 16 or more
// bytes are held, every byte makes the parser read the 16 header bytes back through
// the read port; a frame with a body then has its first and last body byte read for the
// brace check, and a resync after a bad magic reads the held bytes one per cycle.
// The buffer memory needs no clearing pass after reset. A finished result waits in an
// output register while the next request is taken.
module magic_length_frame_deframer_core
   import mlfd_pkg::*;
#(
   parameter int unsigned LINK_COUNT   = DEF_LINK_COUNT,
   parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // link[1:0], data_byte[9:2], zeros[15:10]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_link[1:0], message_type[17:2],
                                    // sequence_res[49:18], body_length[59:50], zeros
   output logic [2:0]  rsp_tuser,   // is_error[0], error_code[2:1]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [9:0]  csr_wdata
);

   localparam int unsigned LINK_W  = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
   localparam int unsigned PTR_W   = $clog2(BUFFER_BYTES);
   localparam int unsigned FILL_W  = $clog2(BUFFER_BYTES + 1);
   localparam int unsigned SUM_W   = FILL_W + 1;
   localparam int unsigned LEN_W   = ((FILL_W > 11) ? FILL_W : 11) + 1;
   localparam int unsigned MEM_DEPTH = LINK_COUNT << PTR_W;
   localparam int unsigned ADDR_W  = LINK_W + PTR_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_HDR, ST_CHECK, ST_SCAN, ST_BRACE, ST_EMIT
   } state_type;

   // Ring position relative to a head, wrapped at the buffer size.
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] h,
                                                 input logic [FILL_W-1:0] p);
      logic [SUM_W-1:0] s;
      s = SUM_W'(h) + SUM_W'(p);
      if (s >= SUM_W'(BUFFER_BYTES)) begin
         s = s - SUM_W'(BUFFER_BYTES);
      end
      return s[PTR_W-1:0];
   endfunction

   // Registers.
   state_type         state_ff, state_in;
   logic [1:0]        link_ff, link_in;
   logic [FILL_W-1:0] pos_ff, pos_in;
   logic              rv_ff;
   logic [FILL_W-1:0] rpos_ff;
   logic              rsel_ff;
   logic [7:0]        rdata_ff;
   logic [7:0]        hdr_ff [HEADER_BYTES];
   logic [7:0]        prev_ff;
   logic              open_ok_ff, open_ok_in;
   logic [1:0]        bcnt_ff, bcnt_in;
   result_type        res_ff, res_in;
   result_type        rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FILL_W-1:0] fill_ff [LINK_COUNT];
   logic [PTR_W-1:0]  head_ff [LINK_COUNT];
   logic [7:0]        ver_ff;
   logic [9:0]        maxb_ff;
   logic [7:0]        mem [MEM_DEPTH];

   // Control signals.
   logic              accept;
   logic              link_ok;
   logic [LINK_W-1:0] cur_idx;
   logic [FILL_W-1:0] cur_fill;
   logic [PTR_W-1:0]  cur_head;
   logic              issue;
   logic [FILL_W-1:0] issue_pos;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic              upd_en, upd_clear;
   logic [FILL_W-1:0] upd_fill, drop_n;
   logic              drop_en, clear_en;
   logic              hdr_shift;
   logic [31:0]       blen, seqn;
   logic [15:0]       mtype;
   logic [10:0]       flen;
   logic [FILL_W-1:0] flen_last;
   logic              magic_ok, version_ok;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign link_ok    = ({30'b0, req_tdata[1:0]} < 32'(LINK_COUNT));
   assign cur_idx    = (state_ff == ST_IDLE) ? LINK_W'(req_tdata[1:0]) : LINK_W'(link_ff);
   assign cur_fill   = fill_ff[cur_idx];
   assign cur_head   = head_ff[cur_idx];

   // Header fields.
   assign mtype      = {hdr_ff[4], hdr_ff[5]};
   assign seqn       = {hdr_ff[8], hdr_ff[9], hdr_ff[10], hdr_ff[11]};
   assign blen       = {hdr_ff[12], hdr_ff[13], hdr_ff[14], hdr_ff[15]};
   assign flen       = 11'(HEADER_BYTES) + 11'(blen[9:0]);
   assign flen_last  = FILL_W'(flen - 11'd1);
   assign magic_ok   = (hdr_ff[0] == MAGIC_FIRST) && (hdr_ff[1] == MAGIC_SECOND);
   assign version_ok = (hdr_ff[2] == ver_ff) && (hdr_ff[3] == 8'(HEADER_BYTES));

   // Memory addressing.
   assign mem_waddr = {cur_idx, wrap_add(cur_head, cur_fill)};
   assign mem_raddr = {cur_idx, wrap_add(cur_head, issue_pos)};

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      link_in      = link_ff;
      pos_in       = pos_ff;
      open_ok_in   = open_ok_ff;
      bcnt_in      = bcnt_ff;
      res_in       = res_ff;
      issue        = 1'b0;
      issue_pos    = pos_ff;
      mem_we       = 1'b0;
      upd_en       = 1'b0;
      upd_clear    = 1'b0;
      upd_fill     = cur_fill;
      drop_en      = 1'b0;
      drop_n       = '0;
      clear_en     = 1'b0;
      hdr_shift    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && link_ok) begin
               link_in = req_tdata[1:0];
               if (req_tuser == KIND_LINK_RESET) begin
                  clear_en = 1'b1;
               end else if (cur_fill >= FILL_W'(BUFFER_BYTES)) begin
                  clear_en = 1'b1;
                  res_in   = '{1'b1, ERR_TOO_LARGE, req_tdata[1:0], 16'd0, 32'd0, 10'd0};
                  state_in = ST_EMIT;
               end else begin
                  mem_we   = 1'b1;
                  upd_en   = 1'b1;
                  upd_fill = cur_fill + FILL_W'(1);
                  if (upd_fill >= FILL_W'(HEADER_BYTES)) begin
                     pos_in   = '0;
                     state_in = ST_HDR;
                  end
               end
            end
         end
         ST_HDR: begin
            // Read the 16 header bytes back into the shift register.
            if (pos_ff < FILL_W'(HEADER_BYTES)) begin
               issue  = 1'b1;
               pos_in = pos_ff + FILL_W'(1);
            end
            if (rv_ff) begin
               hdr_shift = 1'b1;
               if (rpos_ff == FILL_W'(HEADER_BYTES - 1)) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!magic_ok) begin
               pos_in   = '0;
               state_in = ST_SCAN;
            end else if (!version_ok) begin
               drop_en  = 1'b1;
               drop_n   = FILL_W'(1);
               res_in   = '{1'b1, ERR_BAD_VERSION, link_ff, 16'd0, 32'd0, 10'd0};
               state_in = ST_EMIT;
            end else if (blen > {22'b0, maxb_ff}) begin
               clear_en = 1'b1;
               res_in   = '{1'b1, ERR_TOO_LARGE, link_ff, 16'd0, seqn, 10'd0};
               state_in = ST_EMIT;
            end else if (LEN_W'(flen) > LEN_W'(cur_fill)) begin
               state_in = ST_IDLE;
            end else if (blen[9:0] == 10'd0) begin
               drop_en  = 1'b1;
               drop_n   = FILL_W'(flen);
               res_in   = '{1'b0, ERR_BAD_MAGIC, link_ff, mtype, seqn, 10'd0};
               state_in = ST_EMIT;
            end else begin
               bcnt_in  = '0;
               state_in = ST_BRACE;
            end
         end
         ST_SCAN: begin
            // Walk the held bytes looking for the next magic pair.
            if (pos_ff < cur_fill) begin
               issue  = 1'b1;
               pos_in = pos_ff + FILL_W'(1);
            end
            if (rv_ff) begin
               res_in = '{1'b1, ERR_BAD_MAGIC, link_ff, 16'd0, 32'd0, 10'd0};
               if (rpos_ff != '0 && prev_ff == MAGIC_FIRST && rdata_ff == MAGIC_SECOND) begin
                  drop_en  = 1'b1;
                  drop_n   = rpos_ff - FILL_W'(1);
                  state_in = ST_EMIT;
               end else if (rpos_ff == cur_fill - FILL_W'(1)) begin
                  if (rdata_ff == MAGIC_FIRST) begin
                     drop_en = 1'b1;
                     drop_n  = rpos_ff;
                  end else begin
                     clear_en = 1'b1;
                  end
                  state_in = ST_EMIT;
               end
            end
         end
         ST_BRACE: begin
            // Read the first and the last body byte.
            issue_pos = (bcnt_ff == 2'd0) ? FILL_W'(HEADER_BYTES) : flen_last;
            if (bcnt_ff < 2'd2) begin
               issue   = 1'b1;
               bcnt_in = bcnt_ff + 2'd1;
            end
            if (rv_ff) begin
               if (!rsel_ff) begin
                  open_ok_in = (rdata_ff == BRACE_OPEN);
               end else begin
                  drop_en = 1'b1;
                  drop_n  = FILL_W'(flen);
                  if (open_ok_ff && rdata_ff == BRACE_CLOSE) begin
                     res_in = '{1'b0, ERR_BAD_MAGIC, link_ff, mtype, seqn, blen[9:0]};
                  end else begin
                     res_in = '{1'b1, ERR_BAD_BRACES, link_ff, 16'd0, seqn, 10'd0};
                  end
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ver_ff       <= RESET_VERSION;
         maxb_ff      <= RESET_MAX_BODY;
         for (int i = 0; i < int'(LINK_COUNT); i++) begin
            fill_ff[i] <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rv_ff        <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_EXPECTED_VERSION: ver_ff  <= csr_wdata[7:0];
               CSR_MAX_BODY_BYTES:   maxb_ff <= csr_wdata;
               default: ;
            endcase
         end
         // Link fill and head bookkeeping.
         if (clear_en || upd_clear) begin
            fill_ff[cur_idx] <= '0;
            head_ff[cur_idx] <= '0;
         end else if (upd_en) begin
            fill_ff[cur_idx] <= upd_fill;
         end else if (drop_en) begin
            if (drop_n >= cur_fill) begin
               fill_ff[cur_idx] <= '0;
               head_ff[cur_idx] <= '0;
            end else begin
               fill_ff[cur_idx] <= cur_fill - drop_n;
               head_ff[cur_idx] <= wrap_add(cur_head, drop_n);
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      link_ff    <= link_in;
      pos_ff     <= pos_in;
      open_ok_ff <= open_ok_in;
      bcnt_ff    <= bcnt_in;
      res_ff     <= res_in;
      rpos_ff    <= issue_pos;
      rsel_ff    <= bcnt_ff[0];
      if (rv_ff) begin
         prev_ff <= rdata_ff;
      end
      if (hdr_shift) begin
         for (int k = 0; k < int'(HEADER_BYTES) - 1; k++) begin
            hdr_ff[k] <= hdr_ff[k + 1];
         end
         hdr_ff[HEADER_BYTES - 1] <= rdata_ff;
      end
      if (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_ff <= res_ff;
      end
   end

   // Link buffer memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_tdata[9:2];
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.error_code, rsp_ff.is_error};
   assign rsp_tdata  = {4'b0, rsp_ff.body_length, rsp_ff.sequence_res,
                        rsp_ff.message_type, rsp_ff.out_link};

endmodule

>>> src/mlfd_checker.sv
// Port checker for the magic/length frame deframer core, with its bind.
// Depends on mlfd_pkg.
`timescale 1ns / 1ps
module mlfd_checker
   import mlfd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // An accepted frame carries no error code.
   a_frame_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[2:1] == ERR_BAD_MAGIC)
      else $error("frame result with error code");

   // Error reports carry no type and no body length.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[17:2] == 16'd0 && rsp_tdata[59:50] == 10'd0)
      else $error("error result with frame fields");

   // Magic and version errors carry no sequence number.
   a_error_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] &&
      (rsp_tuser[2:1] == ERR_BAD_MAGIC || rsp_tuser[2:1] == ERR_BAD_VERSION)
      |-> rsp_tdata[49:18] == 32'd0)
      else $error("header error with sequence number");

endmodule

bind magic_length_frame_deframer_core mlfd_checker u_mlfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> sim/magic_length_frame_deframer_core_test.sv
// Self-checking test for the magic/length frame deframer core.
// Drives byte and link-reset requests, predicts frame and error results, checks each one.
// Depends on mlfd_pkg and magic_length_frame_deframer_core.
`timescale 1ns / 1ps

// Keeps its own copy of the link buffers and registers, and a queue of
// predicted results in arrival order.
class deframer_scoreboard;
   logic [7:0]  link_mem [4][1024];
   int unsigned link_fill [4];
   int unsigned link_head [4];
   logic [7:0]  cfg_version;
   logic [9:0]  cfg_max_body;
   mlfd_pkg::result_type pending_results [$];
   int unsigned mismatch_count;
   int unsigned frames_seen;
   int unsigned errors_seen;

   function new();
      cfg_version = mlfd_pkg::RESET_VERSION;
      cfg_max_body = mlfd_pkg::RESET_MAX_BODY;
      mismatch_count = 0;
      frames_seen = 0;
      errors_seen = 0;
      for (int l = 0; l < 4; l++) begin
         link_fill[l] = 0;
         link_head[l] = 0;
      end
   endfunction

   function void write_register(logic index, logic [9:0] value);
      if (index == mlfd_pkg::CSR_EXPECTED_VERSION) cfg_version = value[7:0];
      else cfg_max_body = value;
   endfunction

   function logic [7:0] held_byte(int l, int unsigned pos);
      return link_mem[l][(link_head[l] + pos) % 1024];
   endfunction

   function void trim_front(int l, int unsigned n);
      if (n >= link_fill[l]) begin
         link_fill[l] = 0;
         link_head[l] = 0;
      end else begin
         link_head[l] = (link_head[l] + n) % 1024;
         link_fill[l] -= n;
      end
   endfunction

   function void push_result(logic err, mlfd_pkg::err_code_type code, int l,
                             logic [15:0] mtype, logic [31:0] seq, logic [9:0] blen);
      mlfd_pkg::result_type r;
      r.is_error = err;
      r.error_code = code;
      r.out_link = l[1:0];
      r.message_type = mtype;
      r.sequence_res = seq;
      r.body_length = blen;
      pending_results.push_back(r);
   endfunction

   // Works out what one accepted request produces.
   function void note_request(logic kind, logic [1:0] link_id, logic [7:0] data);
      int l;
      int unsigned fill, pos, flen;
      logic [31:0] seq, blen;
      logic [15:0] mtype;
      bit found;
      l = link_id;
      if (kind == mlfd_pkg::KIND_LINK_RESET) begin
         link_fill[l] = 0;
         link_head[l] = 0;
         return;
      end
      // A byte arriving on a full ring clears the link.
      if (link_fill[l] >= 1024) begin
         link_fill[l] = 0;
         link_head[l] = 0;
         push_result(1'b1, mlfd_pkg::ERR_TOO_LARGE, l, 16'h0, 32'h0, 10'h0);
         return;
      end
      link_mem[l][(link_head[l] + link_fill[l]) % 1024] = data;
      link_fill[l]++;
      fill = link_fill[l];
      if (fill < mlfd_pkg::HEADER_BYTES) return;

      // Bad magic: resync to the next magic pair, or keep a trailing first magic byte.
      if (held_byte(l, 0) != mlfd_pkg::MAGIC_FIRST || held_byte(l, 1) != mlfd_pkg::MAGIC_SECOND)
      begin
         found = 0;
         for (pos = 0; pos + 1 < fill; pos++) begin
            if (held_byte(l, pos) == mlfd_pkg::MAGIC_FIRST &&
                held_byte(l, pos + 1) == mlfd_pkg::MAGIC_SECOND) begin
               found = 1;
               break;
            end
         end
         if (found) trim_front(l, pos);
         else if (held_byte(l, fill - 1) == mlfd_pkg::MAGIC_FIRST) trim_front(l, fill - 1);
         else trim_front(l, fill);
         push_result(1'b1, mlfd_pkg::ERR_BAD_MAGIC, l, 16'h0, 32'h0, 10'h0);
         return;
      end

      if (held_byte(l, 2) != cfg_version || held_byte(l, 3) != mlfd_pkg::HEADER_BYTES) begin
         trim_front(l, 1);
         push_result(1'b1, mlfd_pkg::ERR_BAD_VERSION, l, 16'h0, 32'h0, 10'h0);
         return;
      end

      mtype = {held_byte(l, 4), held_byte(l, 5)};
      seq = {held_byte(l, 8), held_byte(l, 9), held_byte(l, 10), held_byte(l, 11)};
      blen = {held_byte(l, 12), held_byte(l, 13), held_byte(l, 14), held_byte(l, 15)};
      if (blen > cfg_max_body) begin
         trim_front(l, fill);
         push_result(1'b1, mlfd_pkg::ERR_TOO_LARGE, l, 16'h0, seq, 10'h0);
         return;
      end
      flen = mlfd_pkg::HEADER_BYTES + blen;
      if (flen > fill) return;
      if (blen != 0 && (held_byte(l, mlfd_pkg::HEADER_BYTES) != mlfd_pkg::BRACE_OPEN ||
                        held_byte(l, flen - 1) != mlfd_pkg::BRACE_CLOSE)) begin
         trim_front(l, flen);
         push_result(1'b1, mlfd_pkg::ERR_BAD_BRACES, l, 16'h0, seq, 10'h0);
         return;
      end
      trim_front(l, flen);
      push_result(1'b0, mlfd_pkg::ERR_BAD_MAGIC, l, mtype, seq, blen[9:0]);
   endfunction

   // Compares one accepted result with the oldest prediction.
   function void check_result(mlfd_pkg::result_type got);
      mlfd_pkg::result_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected result: %p", got);
         mismatch_count++;
         return;
      end
      want = pending_results.pop_front();
      if (got.is_error) errors_seen++;
      else frames_seen++;
      if (got.is_error !== want.is_error) begin
         $error("is_error: expected %0d, got %0d", want.is_error, got.is_error);
         mismatch_count++;
      end
      if (got.error_code !== want.error_code) begin
         $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
         mismatch_count++;
      end
      if (got.out_link !== want.out_link) begin
         $error("out_link: expected %0d, got %0d", want.out_link, got.out_link);
         mismatch_count++;
      end
      if (got.message_type !== want.message_type) begin
         $error("message_type: expected %h, got %h", want.message_type, got.message_type);
         mismatch_count++;
      end
      if (got.sequence_res !== want.sequence_res) begin
         $error("sequence_res: expected %h, got %h", want.sequence_res, got.sequence_res);
         mismatch_count++;
      end
      if (got.body_length !== want.body_length) begin
         $error("body_length: expected %0d, got %0d", want.body_length, got.body_length);
         mismatch_count++;
      end
   endfunction
endclass

module magic_length_frame_deframer_core_test;
   import mlfd_pkg::*;

   localparam int unsigned WATCHDOG_CYCLES = 20000;
   localparam int unsigned SETTLE_CYCLES   = 1100;
   localparam int unsigned PHASE_REQUESTS  = 45;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we = 0;
   logic        csr_index = 0;
   logic [9:0]  csr_wdata = '0;

   deframer_scoreboard tracker = new();
   int unsigned requests_sent = 0;
   int unsigned idle_gap = 0;
   int unsigned stall_request = 0;
   logic [7:0]  cur_version = RESET_VERSION;
   logic [9:0]  cur_max_body = RESET_MAX_BODY;

   magic_length_frame_deframer_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Offers one request and holds it until the block takes it.
   task automatic send_request(logic kind, logic [1:0] link_id, logic [7:0] data);
      if (idle_gap != 0 && $urandom_range(99) < idle_gap) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {6'b0, data, link_id};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(kind, link_id, data);
      requests_sent++;
   endtask

   task automatic send_frame(logic [1:0] link_id, logic [7:0] version, logic [7:0] hlen,
                             logic [31:0] blen, bit good_braces);
      logic [7:0] bytes [$];
      logic [15:0] mtype;
      logic [31:0] seq;
      mtype = $urandom;
      seq = $urandom;
      bytes = {MAGIC_FIRST, MAGIC_SECOND, version, hlen, mtype[15:8], mtype[7:0],
               8'($urandom), 8'($urandom), seq[31:24], seq[23:16], seq[15:8], seq[7:0],
               blen[31:24], blen[23:16], blen[15:8], blen[7:0]};
      if (blen <= 1008) begin
         for (int k = 0; k < blen; k++) bytes.push_back(8'($urandom));
         if (blen != 0 && good_braces) begin
            bytes[16] = BRACE_OPEN;
            bytes[16 + blen - 1] = BRACE_CLOSE;
         end
      end
      foreach (bytes[k]) send_request(KIND_BYTE, link_id, bytes[k]);
   endtask

   task automatic send_noise(logic [1:0] link_id, int count);
      logic [7:0] b;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(3))
            0: b = MAGIC_FIRST;
            1: b = MAGIC_SECOND;
            default: b = $urandom;
         endcase
         send_request(KIND_BYTE, link_id, b);
      end
   endtask

   // Waits until every predicted result has come back, then lets the block settle.
   task automatic drain_and_settle();
      req_tvalid <= 0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic index, logic [9:0] value);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      tracker.write_register(index, value);
      if (index == CSR_EXPECTED_VERSION) cur_version = value[7:0];
      else cur_max_body = value;
   endtask

   // Result side: checks accepted results and stalls at random.
   initial begin
      int hold_left;
      mlfd_pkg::result_type got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.is_error = rsp_tuser[0];
            got.error_code = err_code_type'(rsp_tuser[2:1]);
            got.out_link = rsp_tdata[1:0];
            got.message_type = rsp_tdata[17:2];
            got.sequence_res = rsp_tdata[49:18];
            got.body_length = rsp_tdata[59:50];
            tracker.check_result(got);
         end
         if (stall_request != 0) begin
            hold_left = stall_request;
            stall_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= (idle_gap == 0) ? 1'b1 : ($urandom_range(99) >= idle_gap);
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int choice;
      logic [1:0] lk;
      bit big_done;
      int unsigned phase_start;
      big_done = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part with reset register values.
      idle_gap = 0;
      send_frame(2'd0, RESET_VERSION, 8'(HEADER_BYTES), 0, 1);
      send_frame(2'd1, RESET_VERSION, 8'(HEADER_BYTES), 3, 1);
      send_frame(2'd2, RESET_VERSION, 8'(HEADER_BYTES), 4, 0);
      send_noise(2'd3, 18);                              // bad magic and resync
      send_frame(2'd3, 8'd7, 8'(HEADER_BYTES), 0, 1);    // wrong version
      send_frame(2'd0, RESET_VERSION, 8'd15, 0, 1);      // wrong header length
      send_frame(2'd1, RESET_VERSION, 8'(HEADER_BYTES), 32'hFFFF_FFFF, 1); // too large
      send_noise(2'd2, 5);
      send_request(KIND_LINK_RESET, 2'd2, 8'hFF);        // reset mid-header
      send_frame(2'd2, RESET_VERSION, 8'(HEADER_BYTES), 2, 1);
      drain_and_settle();

      // Register extremes, then random settings; phase 1 adds one long frame.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin write_register(CSR_EXPECTED_VERSION, 10'd0);
                     write_register(CSR_MAX_BODY_BYTES, 10'd0); end
            1: begin write_register(CSR_EXPECTED_VERSION, 10'd255);
                     write_register(CSR_MAX_BODY_BYTES, 10'd1008); end
            default: begin write_register(CSR_EXPECTED_VERSION, 10'($urandom_range(255)));
                     write_register(CSR_MAX_BODY_BYTES, 10'($urandom_range(1008))); end
         endcase
         idle_gap = (phase == 2) ? 0 : 28;
         if (phase == 3) stall_request = 400;
         phase_start = requests_sent;
         while (requests_sent < phase_start + PHASE_REQUESTS) begin
            lk = $urandom_range(3);
            choice = $urandom_range(99);
            if (choice < 70) begin
               send_frame(lk, ($urandom_range(9) == 0) ? 8'($urandom) : cur_version,
                          ($urandom_range(14) == 0) ? 8'($urandom) : 8'(HEADER_BYTES),
                          ($urandom_range(9) == 0) ? 32'($urandom_range(40)) :
                          32'($urandom_range(cur_max_body < 12 ? cur_max_body : 12)),
                          $urandom_range(6) != 0);
            end else if (choice < 80) begin
               send_request(KIND_LINK_RESET, lk, 8'($urandom));
            end else begin
               send_noise(lk, $urandom_range(1, 8));
            end
         end
         if (phase == 1 && !big_done) begin
            send_frame(2'd3, cur_version, 8'(HEADER_BYTES), 120, 1);
            big_done = 1;
         end
         drain_and_settle();
      end

      $display("Covered %0d requests: %0d accepted frames and %0d error reports checked.",
               requests_sent, tracker.frames_seen, tracker.errors_seen);
      $display("Register settings included both version extremes and body limits 0 and 1008.");
      if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
